/* src/skt_pkg.sv */
// Package for the sorted key table engine: request and status codes,
// payload structs and the key normalization function. No dependencies.
package skt_pkg;

  localparam logic [1:0] REQ_FIND   = 2'd0;
  localparam logic [1:0] REQ_ENTER  = 2'd1;
  localparam logic [1:0] REQ_DELETE = 2'd2;
  localparam logic [1:0] REQ_NOP    = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_BAD_POS   = 2'd3;

  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [7:0]  key_first;
    logic [7:0]  key_second;
    logic [31:0] value_in;
    logic [7:0]  entry_index;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  position;
    logic [31:0] value_out;
  } rsp_t;

  // Classified command handed from the front part to the back part.
  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] key;
    logic [31:0] value;
    logic [7:0]  index;
  } cmd_t;

  typedef enum logic [2:0] {
    BK_IDLE, BK_SRCH, BK_SWAIT, BK_DECIDE, BK_SHRD, BK_SHWR, BK_RESP
  } bk_state_t;

  function automatic logic [15:0] norm_key(input logic [7:0] f, input logic [7:0] s);
    logic [7:0] s2;
    s2 = (s == CHAR_SPACE || s == CHAR_TAB) ? 8'd0 : s;
    return {f, s2};
  endfunction

endpackage

/* src/skt_if.sv */
// Valid/ready channel interfaces for the sorted key table engine.
// Depends on skt_pkg.
interface skt_req_if import skt_pkg::*; ();
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface skt_rsp_if import skt_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* src/sorted_key_table_engine.sv */
// Sorted key table engine. Find and enter run a binary search over the
// table; a new entry or a delete then shifts the entries one at a time,
// each read and written back through the single read and write port of the table memory.
// A two-word queue lets new words enter while the back part works.
// Synchronous active-low reset empties the table and the queue; entries
// are not cleared, the entry count alone marks what is occupied.
module sorted_key_table_engine import skt_pkg::*; #(
  parameter int TABLE_DEPTH = 256
) (
  input logic clk,
  input logic rst_n,
  skt_req_if.sink   in_ch,
  skt_rsp_if.source out_ch
);
  logic cmd_valid, cmd_ready;
  cmd_t cmd_data;

  skt_front u_front (
    .clk, .rst_n,
    .in_valid (in_ch.valid), .in_ready (in_ch.ready), .in_data (in_ch.data),
    .cmd_valid, .cmd_ready, .cmd_data
  );

  skt_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
    .clk, .rst_n, .cmd_valid, .cmd_ready, .cmd_data,
    .out_valid (out_ch.valid), .out_ready (out_ch.ready), .out_data (out_ch.data)
  );

`ifndef SYNTHESIS
  // A failed request never reports a position or a value.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.data.status != ST_OK |->
      out_ch.data.position == 8'd0 && out_ch.data.value_out == 32'd0)
    else $error("failed request with nonzero payload");
  // The back part takes no command while a result is pending.
  a_no_take: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !cmd_ready)
    else $error("command taken while result pending");
`endif
endmodule

/* src/skt_front.sv */
// Front part: accepts request words, normalizes the key and queues a
// command for the back part in a two-entry queue. Depends on skt_pkg.
module skt_front import skt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  req_t        in_data,
  output logic        cmd_valid,
  input  logic        cmd_ready,
  output cmd_t        cmd_data
);
  cmd_t       q_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push, pop;

  assign in_ready  = (cnt_r != 2'd2);
  assign push      = in_valid && in_ready;
  assign cmd_valid = (cnt_r != 2'd0);
  assign pop       = cmd_valid && cmd_ready;
  assign cmd_data  = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r].op    <= in_data.req_type;
      q_r[wp_r].key   <= norm_key(in_data.key_first, in_data.key_second);
      q_r[wp_r].value <= in_data.value_in;
      q_r[wp_r].index <= in_data.entry_index;
    end
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

/* src/skt_back.sv */
// Back part: holds the sorted table in memories, runs the binary search
// and the entry-by-entry shift, a read then a write per entry, on insert and delete.
// Depends on skt_pkg.
module skt_back import skt_pkg::*; #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic clk,
  input  logic rst_n,
  input  logic cmd_valid,
  output logic cmd_ready,
  input  cmd_t cmd_data,
  output logic out_valid,
  input  logic out_ready,
  output rsp_t out_data
);
  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = AW + 1;
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  logic [15:0] key_mem [TABLE_DEPTH];
  logic [31:0] val_mem [TABLE_DEPTH];

  bk_state_t st_r, st_nxt;
  cmd_t      cmd_r;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] lo_r, lo_nxt, hi_r, hi_nxt, mid_r, mid_nxt;
  logic [CW-1:0] ptr_r, ptr_nxt;
  logic          hit_r, hit_nxt;
  rsp_t          rsp_r, rsp_nxt;
  logic          load;

  // Memory port control.
  logic [AW-1:0] rd_addr;
  logic [15:0]   rd_key_r;
  logic [31:0]   rd_val_r;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [15:0]   wr_key;
  logic [31:0]   wr_val;

  always_ff @(posedge clk) begin
    rd_key_r <= key_mem[rd_addr];
    rd_val_r <= val_mem[rd_addr];
    if (wr_en) begin
      key_mem[wr_addr] <= wr_key;
      val_mem[wr_addr] <= wr_val;
    end
  end

  assign cmd_ready = (st_r == BK_IDLE);
  assign load      = cmd_valid && cmd_ready;
  assign out_valid = (st_r == BK_RESP);
  assign out_data  = rsp_r;

  always_comb begin
    st_nxt    = st_r;
    count_nxt = count_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    mid_nxt   = mid_r;
    ptr_nxt   = ptr_r;
    hit_nxt   = hit_r;
    rsp_nxt   = rsp_r;
    rd_addr   = mid_r[AW-1:0];
    wr_en     = 1'b0;
    wr_addr   = ptr_r[AW-1:0];
    wr_key    = cmd_r.key;
    wr_val    = cmd_r.value;
    unique case (st_r)
      BK_IDLE: begin
        if (load) begin
          lo_nxt  = '0;
          hi_nxt  = count_r;
          hit_nxt = 1'b0;
          rsp_nxt = '0;
          st_nxt  = (cmd_data.op == REQ_DELETE) ? BK_DECIDE :
                    (cmd_data.op == REQ_NOP) ? BK_RESP : BK_SRCH;
        end
      end
      BK_SRCH: begin
        if (lo_r < hi_r) begin
          mid_nxt = lo_r + ((hi_r - lo_r) >> 1);
          rd_addr = mid_nxt[AW-1:0];
          st_nxt  = BK_SWAIT;
        end else begin
          st_nxt = BK_DECIDE;
        end
      end
      BK_SWAIT: begin
        // Read data for mid was registered in the previous cycle.
        st_nxt = BK_SRCH;
        if (cmd_r.key < rd_key_r) begin
          hi_nxt = mid_r;
        end else if (cmd_r.key > rd_key_r) begin
          lo_nxt = mid_r + 1'b1;
        end else begin
          hit_nxt = 1'b1;
          lo_nxt  = mid_r;
          st_nxt  = BK_DECIDE;
          if (cmd_r.op == REQ_FIND) rsp_nxt.value_out = rd_val_r;
        end
      end
      BK_DECIDE: begin
        st_nxt = BK_RESP;
        priority if (cmd_r.op == REQ_FIND) begin
          if (hit_r) rsp_nxt.position = 8'(lo_r);
          else rsp_nxt.status = ST_NOT_FOUND;
        end else if (cmd_r.op == REQ_ENTER) begin
          if (hit_r) begin
            wr_en   = 1'b1;
            wr_addr = lo_r[AW-1:0];
            rsp_nxt.position = 8'(lo_r);
          end else if (count_r >= DEPTH_C) begin
            rsp_nxt.status = ST_FULL;
          end else begin
            rsp_nxt.position = 8'(lo_r);
            ptr_nxt = count_r;
            st_nxt  = BK_SHRD;
          end
        end else begin
          if (int'(cmd_r.index) >= int'(count_r)) begin
            rsp_nxt.status = ST_BAD_POS;
          end else begin
            rsp_nxt.position = cmd_r.index;
            ptr_nxt = CW'(cmd_r.index);
            st_nxt  = BK_SHRD;
          end
        end
      end
      BK_SHRD: begin
        // Insert walks down from the top; delete walks up from the hole.
        if (cmd_r.op == REQ_ENTER) begin
          if (ptr_r > lo_r) begin
            rd_addr = AW'(ptr_r - 1'b1);
            st_nxt  = BK_SHWR;
          end else begin
            wr_en     = 1'b1;
            wr_addr   = lo_r[AW-1:0];
            count_nxt = count_r + 1'b1;
            st_nxt    = BK_RESP;
          end
        end else begin
          if (ptr_r + 1'b1 < count_r) begin
            rd_addr = AW'(ptr_r + 1'b1);
            st_nxt  = BK_SHWR;
          end else begin
            count_nxt = count_r - 1'b1;
            st_nxt    = BK_RESP;
          end
        end
      end
      BK_SHWR: begin
        wr_en   = 1'b1;
        wr_key  = rd_key_r;
        wr_val  = rd_val_r;
        ptr_nxt = (cmd_r.op == REQ_ENTER) ? ptr_r - 1'b1 : ptr_r + 1'b1;
        st_nxt  = BK_SHRD;
      end
      BK_RESP: begin
        if (out_ready) st_nxt = BK_IDLE;
      end
      default: st_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (load) cmd_r <= cmd_data;
    lo_r  <= lo_nxt;
    hi_r  <= hi_nxt;
    mid_r <= mid_nxt;
    ptr_r <= ptr_nxt;
    hit_r <= hit_nxt;
    rsp_r <= rsp_nxt;
    if (!rst_n) begin
      st_r    <= BK_IDLE;
      count_r <= '0;
    end else begin
      st_r    <= st_nxt;
      count_r <= count_nxt;
    end
  end
endmodule
